[design/uart_commanded_motor_pwm_control_core_defines.svh]
// Assertion macros shared by the motor controller core.
`ifndef UART_COMMANDED_MOTOR_PWM_CONTROL_CORE_DEFINES_SVH
`define UART_COMMANDED_MOTOR_PWM_CONTROL_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define UCMPC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define UCMPC_ASSERT_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

[design/ucmpc_pkg.sv]
// Types and constants of the motor controller core.
package ucmpc_pkg;

   localparam int ADC_BITS    = 12;
   localparam int PERIOD_BITS = 24;
   localparam int DUTY_BITS   = 7;
   localparam int PROD_BITS   = PERIOD_BITS + DUTY_BITS;

   localparam logic [1:0] CMD_CHAR   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_EXPIRY = 2'd2;
   localparam logic [1:0] CMD_BUTTON = 2'd3;

   localparam logic [2:0] MODE_DIRSEL      = 3'd0;
   localparam logic [2:0] MODE_MODESEL_CCW = 3'd1;
   localparam logic [2:0] MODE_MODESEL_CW  = 3'd2;
   localparam logic [2:0] MODE_TERM_CCW    = 3'd3;
   localparam logic [2:0] MODE_TERM_CW     = 3'd4;
   localparam logic [2:0] MODE_POT_CW      = 3'd5;
   localparam logic [2:0] MODE_POT_CCW     = 3'd6;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_CCW  = 2'd1;
   localparam logic [1:0] DIR_CW   = 2'd2;

   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_H    = 8'h68;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_SIX  = 8'h36;

   localparam logic [DUTY_BITS-1:0]   DUTY_FULL    = 7'd100;
   localparam logic [DUTY_BITS-1:0]   DUTY_RESET   = 7'd1;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 24'd79999;

   // Division by 100 is a shift by two and an exact reciprocal multiply by 25.
   localparam int          RECIP_BITS  = 30;
   localparam logic [29:0] RECIP_25    = 30'd687194768;
   localparam int          RECIP_SHIFT = 34;

   typedef struct packed {
      logic [1:0]          command;
      logic [7:0]          char_code;
      logic [ADC_BITS-1:0] pot_sample;
   } req_type;

   typedef struct packed {
      logic [2:0]             mode;
      logic [1:0]             direction;
      logic [DUTY_BITS-1:0]   duty_percent;
      logic                   speed_report;
      logic [PERIOD_BITS-1:0] reload_value;
      logic                   reload_valid;
      logic                   pwm_level;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           mode;
      logic [1:0]           direction;
      logic [DUTY_BITS-1:0] duty_percent;
      logic                 speed_report;
      logic                 reload_valid;
      logic                 pwm_level;
      logic [PROD_BITS-1:0] product;
   } stage_type;

endpackage

[design/ucmpc_ctrl.sv]
// Mode machine, duty and PWM phase state, and the first pipeline stage.
module ucmpc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ucmpc_pkg::req_type                  req_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ucmpc_pkg::PERIOD_BITS-1:0]   csr_data,
   output logic                                stage_valid,
   output ucmpc_pkg::stage_type                stage_data,
   input  logic                                stage_take
);
   import ucmpc_pkg::*;

   logic [PERIOD_BITS-1:0] period_ff;
   logic [2:0]             mode_ff, mode_in;
   logic [1:0]             dir_ff, dir_in;
   logic [DUTY_BITS-1:0]   duty_ff, duty_in;
   logic                   phase_ff, phase_in;
   logic                   pin_ff, pin_in;
   logic                   running_ff, running_in;
   logic                   stage_valid_ff;
   stage_type              stage_ff, stage_in;

   logic                   accept;
   logic                   is_a, is_h, is_digit, mode_change, report;
   logic [2:0]             mode_next;
   logic [7:0]             digit;
   logic [ADC_BITS+6:0]    pot_prod;
   logic [DUTY_BITS-1:0]   pot_duty, part;
   logic [PROD_BITS-1:0]   product;

   function automatic logic [1:0] dir_of(input logic [2:0] m);
      logic [1:0] d;
      if (m == MODE_MODESEL_CCW || m == MODE_TERM_CCW || m == MODE_POT_CCW) begin
         d = DIR_CCW;
      end else begin
         d = DIR_CW;
      end
      return d;
   endfunction

   function automatic logic [DUTY_BITS-1:0] digit_duty(input logic [2:0] d);
      logic [DUTY_BITS-1:0] r;
      case (d)
         3'd1: r = 7'd50;
         3'd2: r = 7'd60;
         3'd3: r = 7'd70;
         3'd4: r = 7'd80;
         3'd5: r = 7'd90;
         3'd6: r = 7'd100;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   assign req_ready   = !stage_valid_ff || stage_take;
   assign accept      = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_ff;

   assign is_a     = (req_data.char_code == CHAR_A);
   assign is_h     = (req_data.char_code == CHAR_H);
   assign is_digit = (req_data.char_code >= CHAR_ZERO) && (req_data.char_code <= CHAR_SIX);
   assign digit    = req_data.char_code - CHAR_ZERO;

   assign pot_prod = (ADC_BITS+7)'(req_data.pot_sample) * (ADC_BITS+7)'(DUTY_FULL);
   assign pot_duty = (pot_prod[ADC_BITS+6:ADC_BITS] > DUTY_FULL) ? DUTY_FULL
                                                                  : pot_prod[ADC_BITS+6:ADC_BITS];
   assign part     = phase_ff ? (DUTY_FULL - duty_ff) : duty_ff;
   assign product  = PROD_BITS'(period_ff) * PROD_BITS'(part);

   always_comb begin
      mode_change = 1'b0;
      mode_next   = mode_ff;
      report      = 1'b0;
      duty_in     = duty_ff;
      phase_in    = phase_ff;
      pin_in      = pin_ff;
      running_in  = running_ff;
      stage_in    = '0;
      unique case (req_data.command)
         CMD_CHAR: begin
            unique case (mode_ff) inside
               MODE_DIRSEL: begin
                  if (is_a) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_MODESEL_CCW;
                  end else if (is_h) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_MODESEL_CW;
                  end
               end
               MODE_MODESEL_CCW: begin
                  if (is_a) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_TERM_CCW;
                  end else if (is_h) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_POT_CCW;
                  end
               end
               MODE_MODESEL_CW: begin
                  if (is_a) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_TERM_CW;
                  end else if (is_h) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_POT_CW;
                  end
               end
               MODE_TERM_CCW, MODE_TERM_CW: begin
                  if (mode_ff == MODE_TERM_CCW && is_h) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_TERM_CW;
                  end else if (mode_ff == MODE_TERM_CW && is_a) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_TERM_CCW;
                  end else if (is_digit) begin
                     duty_in = digit_duty(digit[2:0]);
                     report  = 1'b1;
                  end
               end
               MODE_POT_CW: begin
                  if (is_a) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_POT_CCW;
                  end
               end
               MODE_POT_CCW: begin
                  if (is_h) begin
                     mode_change = 1'b1;
                     mode_next   = MODE_POT_CW;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_SAMPLE: begin
            if (mode_ff == MODE_POT_CW || mode_ff == MODE_POT_CCW) begin
               duty_in = pot_duty;
               report  = 1'b1;
            end
         end
         CMD_EXPIRY: begin
            phase_in              = !phase_ff;
            pin_in                = !pin_ff;
            running_in            = 1'b1;
            stage_in.reload_valid = 1'b1;
            stage_in.product      = product;
         end
         CMD_BUTTON: begin
            running_in = !running_ff;
         end
         default: begin
         end
      endcase
      mode_in = mode_next;
      dir_in  = mode_change ? dir_of(mode_next) : dir_ff;
      stage_in.mode         = mode_in;
      stage_in.direction    = dir_in;
      stage_in.duty_percent = duty_in;
      stage_in.speed_report = report;
      stage_in.pwm_level    = pin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= PERIOD_RESET;
         mode_ff        <= MODE_DIRSEL;
         dir_ff         <= DIR_NONE;
         duty_ff        <= DUTY_RESET;
         phase_ff       <= 1'b0;
         pin_ff         <= 1'b0;
         running_ff     <= 1'b1;
         stage_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            period_ff <= csr_data;
         end
         if (accept) begin
            mode_ff        <= mode_in;
            dir_ff         <= dir_in;
            duty_ff        <= duty_in;
            phase_ff       <= phase_in;
            pin_ff         <= pin_in;
            running_ff     <= running_in;
            stage_valid_ff <= 1'b1;
         end else if (stage_take) begin
            stage_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

[design/ucmpc_reload.sv]
// Divides the reload product by 100 and holds the result word.
module ucmpc_reload (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stage_valid,
   input  ucmpc_pkg::stage_type  stage_data,
   output logic                  stage_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ucmpc_pkg::rsp_type    rsp_data
);
   import ucmpc_pkg::*;

   localparam int QUARTER_BITS = PROD_BITS - 2;
   localparam int WIDE_BITS    = QUARTER_BITS + RECIP_BITS;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic [QUARTER_BITS-1:0] quarter;
   logic [WIDE_BITS-1:0]    wide;

   assign quarter = stage_data.product[PROD_BITS-1:2];
   assign wide    = WIDE_BITS'(quarter) * WIDE_BITS'(RECIP_25);

   always_comb begin
      rsp_in.mode         = stage_data.mode;
      rsp_in.direction    = stage_data.direction;
      rsp_in.duty_percent = stage_data.duty_percent;
      rsp_in.speed_report = stage_data.speed_report;
      rsp_in.reload_value = wide[RECIP_SHIFT+PERIOD_BITS-1:RECIP_SHIFT];
      rsp_in.reload_valid = stage_data.reload_valid;
      rsp_in.pwm_level    = stage_data.pwm_level;
   end

   assign stage_take = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_take) begin
         rsp_valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take && stage_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[design/uart_commanded_motor_pwm_control_core.sv]
// An accepted word is registered in stage one, then in the output register of stage two.
// Throughput: one word per cycle while rsp_ready holds; stage one multiplies period
// by duty or 100 minus duty; stage two divides by 100 with a reciprocal multiply.
// Reset is synchronous: mode direction select, no direction, duty 1 percent,
// PWM pin low, high phase cleared, timer running, period 79999, pipeline empty.
`include "uart_commanded_motor_pwm_control_core_defines.svh"

module uart_commanded_motor_pwm_control_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ucmpc_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ucmpc_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ucmpc_pkg::PERIOD_BITS-1:0]   csr_data
);
   import ucmpc_pkg::*;

   logic      stage_valid;
   logic      stage_take;
   stage_type stage_data;

   ucmpc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take)
   );

   ucmpc_reload u_reload (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   `UCMPC_ASSERT(a_reload_zero, clock, reset,
      (rsp_valid && !rsp_data.reload_valid) |-> (rsp_data.reload_value == '0),
      "Reload value is nonzero on a word that is not a timer expiry.")
   `UCMPC_ASSERT(a_duty_range, clock, reset,
      rsp_valid |-> (rsp_data.duty_percent <= DUTY_FULL),
      "Duty exceeds 100 percent.")
   `UCMPC_ASSERT(a_dir_mode, clock, reset,
      rsp_valid |-> ((rsp_data.mode == MODE_DIRSEL) == (rsp_data.direction == DIR_NONE)),
      "Direction does not match the mode.")
   `UCMPC_ASSERT_NEXT(a_stage_fill, clock, reset, req_valid && req_ready, stage_valid,
      "An accepted word did not reach the first stage.")

endmodule

[sim/tb_top.sv]
// Self-checking testbench of the motor controller core: directed steps, then random words.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ucmpc_pkg::*;

   localparam int RUN_LIMIT = 400000;
   localparam int PHASE_WORDS = 100;
   localparam int PHASES = 6;

   localparam logic [1:0] ROUTE_ALL  = 2'd0;
   localparam logic [1:0] ROUTE_TERM = 2'd1;
   localparam logic [1:0] ROUTE_POT  = 2'd2;

   typedef struct packed {
      logic [1:0] route;
      logic       known;
      req_type    word;
      rsp_type    result;
   } plan_entry;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [PERIOD_BITS-1:0] csr_data = '0;

   logic [2:0]             ctl_mode;
   logic [1:0]             ctl_dir;
   logic [DUTY_BITS-1:0]   ctl_duty;
   logic                   ctl_high_phase;
   logic                   ctl_pin;
   logic                   ctl_running;
   logic [PERIOD_BITS-1:0] ctl_period;

   rsp_type   status_due_q[$];
   rsp_type   status_due;
   plan_entry plan[$];
   bit        req_quiet;
   bit        rsp_quiet;
   int        mismatches;
   int        cycle_count;

   uart_commanded_motor_pwm_control_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void set_mode(logic [2:0] m);
      ctl_mode = m;
      if (m == MODE_MODESEL_CCW || m == MODE_TERM_CCW || m == MODE_POT_CCW) begin
         ctl_dir = DIR_CCW;
      end else if (m == MODE_MODESEL_CW || m == MODE_TERM_CW || m == MODE_POT_CW) begin
         ctl_dir = DIR_CW;
      end
   endfunction

   function automatic rsp_type advance_motor(req_type w);
      rsp_type        r;
      logic           is_a;
      logic           is_h;
      logic [6:0]     part;
      logic [31:0]    prod;
      logic [18:0]    scaled;
      r = '0;
      is_a = (w.char_code == CHAR_A);
      is_h = (w.char_code == CHAR_H);
      case (w.command)
         CMD_CHAR: begin
            case (ctl_mode)
               MODE_DIRSEL: begin
                  if (is_a) set_mode(MODE_MODESEL_CCW);
                  else if (is_h) set_mode(MODE_MODESEL_CW);
               end
               MODE_MODESEL_CCW: begin
                  if (is_a) set_mode(MODE_TERM_CCW);
                  else if (is_h) set_mode(MODE_POT_CCW);
               end
               MODE_MODESEL_CW: begin
                  if (is_a) set_mode(MODE_TERM_CW);
                  else if (is_h) set_mode(MODE_POT_CW);
               end
               MODE_TERM_CCW, MODE_TERM_CW: begin
                  if (ctl_mode == MODE_TERM_CCW && is_h) begin
                     set_mode(MODE_TERM_CW);
                  end else if (ctl_mode == MODE_TERM_CW && is_a) begin
                     set_mode(MODE_TERM_CCW);
                  end else if (w.char_code >= CHAR_ZERO && w.char_code <= CHAR_SIX) begin
                     ctl_duty = (w.char_code == CHAR_ZERO) ? '0 :
                                7'((w.char_code - CHAR_ZERO) * 10 + 40);
                     r.speed_report = 1'b1;
                  end
               end
               MODE_POT_CW: begin
                  if (is_a) set_mode(MODE_POT_CCW);
               end
               MODE_POT_CCW: begin
                  if (is_h) set_mode(MODE_POT_CW);
               end
               default: ;
            endcase
         end
         CMD_SAMPLE: begin
            if (ctl_mode == MODE_POT_CW || ctl_mode == MODE_POT_CCW) begin
               scaled = (19'(w.pot_sample) * 19'd100) >> ADC_BITS;
               ctl_duty = (scaled > 19'(DUTY_FULL)) ? DUTY_FULL : scaled[6:0];
               r.speed_report = 1'b1;
            end
         end
         CMD_EXPIRY: begin
            part = ctl_high_phase ? DUTY_FULL - ctl_duty : ctl_duty;
            prod = 32'(ctl_period) * 32'(part);
            r.reload_value = 24'(prod / 32'd100);
            r.reload_valid = 1'b1;
            ctl_high_phase = ~ctl_high_phase;
            ctl_pin = ~ctl_pin;
            ctl_running = 1'b1;
         end
         default: begin
            ctl_running = ~ctl_running;
         end
      endcase
      r.mode = ctl_mode;
      r.direction = ctl_dir;
      r.duty_percent = ctl_duty;
      r.pwm_level = ctl_pin;
      return r;
   endfunction

   function automatic plan_entry plan_row(logic [1:0] route, logic [1:0] cmd, logic [7:0] ch,
         logic [ADC_BITS-1:0] smp, logic known, logic [2:0] mode, logic [1:0] dir,
         logic [DUTY_BITS-1:0] duty, logic rep, logic [PERIOD_BITS-1:0] reload, logic rv,
         logic pin);
      plan_entry e;
      e.route = route;
      e.known = known;
      e.word.command = cmd;
      e.word.char_code = ch;
      e.word.pot_sample = smp;
      e.result.mode = mode;
      e.result.direction = dir;
      e.result.duty_percent = duty;
      e.result.speed_report = rep;
      e.result.reload_value = reload;
      e.result.reload_valid = rv;
      e.result.pwm_level = pin;
      return e;
   endfunction

   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 31) == 0) quiet = ~quiet;
      return quiet ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic void check_field(string name, longint unsigned want,
         longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_word(input req_type w, input logic known, input rsp_type stated,
         output rsp_type pred);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      pred = advance_motor(w);
      status_due_q.push_back(known ? stated : pred);
   endtask

   task automatic write_period(input logic [PERIOD_BITS-1:0] value);
      req_valid <= 1'b0;
      while (status_due_q.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ctl_period = value;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due_q.size() == 0) begin
            $error("result word arrived with nothing outstanding");
            mismatches++;
         end else begin
            status_due = status_due_q.pop_front();
            check_field("mode", status_due.mode, rsp_data.mode);
            check_field("direction", status_due.direction, rsp_data.direction);
            check_field("duty_percent", status_due.duty_percent, rsp_data.duty_percent);
            check_field("speed_report", status_due.speed_report, rsp_data.speed_report);
            check_field("reload_value", status_due.reload_value, rsp_data.reload_value);
            check_field("reload_valid", status_due.reload_valid, rsp_data.reload_valid);
            check_field("pwm_level", status_due.pwm_level, rsp_data.pwm_level);
         end
      end
   end

   initial begin
      int gap;
      forever begin
         gap = draw_wait(rsp_quiet);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [1:0]             route;
      int                     counted;
      req_type                w;
      rsp_type                pred;
      logic [2:0]             mode_before;
      logic [PERIOD_BITS-1:0] period_pick;
      int                     pick;

      mismatches = 0;
      cycle_count = 0;
      ctl_mode = MODE_DIRSEL;
      ctl_dir = DIR_NONE;
      ctl_duty = DUTY_RESET;
      ctl_high_phase = 1'b0;
      ctl_pin = 1'b0;
      ctl_running = 1'b1;
      ctl_period = PERIOD_RESET;

      plan.push_back(plan_row(ROUTE_ALL, CMD_BUTTON, 8'hFF, 12'hFFF, 1'b1,
                              MODE_DIRSEL, DIR_NONE, 7'd1, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_ALL, CMD_EXPIRY, 8'h00, 12'h000, 1'b1,
                              MODE_DIRSEL, DIR_NONE, 7'd1, 1'b0, 24'd799, 1'b1, 1'b1));
      plan.push_back(plan_row(ROUTE_ALL, CMD_BUTTON, 8'h55, 12'hAAA, 1'b1,
                              MODE_DIRSEL, DIR_NONE, 7'd1, 1'b0, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_ALL, CMD_BUTTON, 8'hAA, 12'h555, 1'b1,
                              MODE_DIRSEL, DIR_NONE, 7'd1, 1'b0, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_ALL, CMD_EXPIRY, 8'hFF, 12'hFFF, 1'b1,
                              MODE_DIRSEL, DIR_NONE, 7'd1, 1'b0, 24'd79199, 1'b1, 1'b0));
      plan.push_back(plan_row(ROUTE_ALL, CMD_SAMPLE, 8'hFF, 12'hFFF, 1'b1,
                              MODE_DIRSEL, DIR_NONE, 7'd1, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_ALL, CMD_CHAR, CHAR_SIX, 12'h000, 1'b1,
                              MODE_DIRSEL, DIR_NONE, 7'd1, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_ALL, CMD_CHAR, 8'h00, 12'hFFF, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_ALL, CMD_CHAR, 8'hFF, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));

      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, CHAR_A, 12'h000, 1'b1,
                              MODE_MODESEL_CCW, DIR_CCW, 7'd1, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, 8'h33, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_SAMPLE, 8'h00, 12'h800, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, CHAR_A, 12'h000, 1'b1,
                              MODE_TERM_CCW, DIR_CCW, 7'd1, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, CHAR_ZERO, 12'h000, 1'b1,
                              MODE_TERM_CCW, DIR_CCW, 7'd0, 1'b1, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_EXPIRY, 8'h00, 12'h000, 1'b1,
                              MODE_TERM_CCW, DIR_CCW, 7'd0, 1'b0, 24'd0, 1'b1, 1'b1));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, CHAR_SIX, 12'h000, 1'b1,
                              MODE_TERM_CCW, DIR_CCW, 7'd100, 1'b1, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_TERM, CMD_EXPIRY, 8'h00, 12'h000, 1'b1,
                              MODE_TERM_CCW, DIR_CCW, 7'd100, 1'b0, 24'd0, 1'b1, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_EXPIRY, 8'h00, 12'h000, 1'b1,
                              MODE_TERM_CCW, DIR_CCW, 7'd100, 1'b0, 24'd79999, 1'b1, 1'b1));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, 8'h37, 12'h000, 1'b1,
                              MODE_TERM_CCW, DIR_CCW, 7'd100, 1'b0, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, CHAR_H, 12'h000, 1'b1,
                              MODE_TERM_CW, DIR_CW, 7'd100, 1'b0, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, 8'h31, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, 8'h2F, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, CHAR_A, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_TERM, CMD_CHAR, 8'h35, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));

      plan.push_back(plan_row(ROUTE_POT, CMD_CHAR, CHAR_H, 12'h000, 1'b1,
                              MODE_MODESEL_CW, DIR_CW, 7'd1, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_CHAR, 8'h33, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_SAMPLE, 8'h00, 12'h064, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_CHAR, CHAR_H, 12'h000, 1'b1,
                              MODE_POT_CW, DIR_CW, 7'd1, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_SAMPLE, 8'h00, 12'h000, 1'b1,
                              MODE_POT_CW, DIR_CW, 7'd0, 1'b1, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_SAMPLE, 8'h00, 12'hFFF, 1'b1,
                              MODE_POT_CW, DIR_CW, 7'd99, 1'b1, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_EXPIRY, 8'h00, 12'h000, 1'b1,
                              MODE_POT_CW, DIR_CW, 7'd99, 1'b0, 24'd79199, 1'b1, 1'b1));
      plan.push_back(plan_row(ROUTE_POT, CMD_CHAR, CHAR_SIX, 12'h000, 1'b1,
                              MODE_POT_CW, DIR_CW, 7'd99, 1'b0, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_POT, CMD_CHAR, CHAR_A, 12'h000, 1'b1,
                              MODE_POT_CCW, DIR_CCW, 7'd99, 1'b0, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_POT, CMD_SAMPLE, 8'h00, 12'h800, 1'b1,
                              MODE_POT_CCW, DIR_CCW, 7'd50, 1'b1, 24'd0, 1'b0, 1'b1));
      plan.push_back(plan_row(ROUTE_POT, CMD_CHAR, CHAR_A, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_CHAR, CHAR_H, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_SAMPLE, 8'h00, 12'h029, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));
      plan.push_back(plan_row(ROUTE_POT, CMD_EXPIRY, 8'h00, 12'h000, 1'b0,
                              MODE_DIRSEL, DIR_NONE, 7'd0, 1'b0, 24'd0, 1'b0, 1'b0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The mode machine never returns to direction select, so each run takes one branch.
      route = $urandom_range(0, 1) ? ROUTE_TERM : ROUTE_POT;
      foreach (plan[i]) begin
         if (plan[i].route == ROUTE_ALL || plan[i].route == route) begin
            send_word(plan[i].word, plan[i].known, plan[i].result, pred);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: period_pick = '1;
            1: period_pick = 24'd1;
            2: period_pick = '0;
            3: period_pick = 24'($urandom);
            4: period_pick = 24'($urandom_range(1, 1000));
            default: period_pick = PERIOD_RESET;
         endcase
         write_period(period_pick);
         counted = 0;
         while (counted < PHASE_WORDS) begin
            w.char_code = 8'($urandom_range(0, 255));
            w.pot_sample = 12'($urandom_range(0, 4095));
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               w.command = CMD_CHAR;
               pick = $urandom_range(0, 19);
               if (pick < 9) begin
                  w.char_code = CHAR_ZERO + 8'($urandom_range(0, 6));
               end else if (pick < 13) begin
                  w.char_code = $urandom_range(0, 1) ? CHAR_A : CHAR_H;
               end
            end else if (pick < 55) begin
               w.command = CMD_SAMPLE;
               if ($urandom_range(0, 9) == 0) w.pot_sample = $urandom_range(0, 1) ? '1 : '0;
            end else if (pick < 85) begin
               w.command = CMD_EXPIRY;
            end else begin
               w.command = CMD_BUTTON;
            end
            mode_before = ctl_mode;
            send_word(w, 1'b0, '0, pred);
            if ((w.command != CMD_CHAR && w.command != CMD_SAMPLE) || pred.speed_report ||
                pred.mode != mode_before) begin
               counted++;
            end
         end
      end

      req_valid <= 1'b0;
      while (status_due_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
